### src/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg: shared types and constants of the custom-base string parser
// Character codes, register indexes, parse phases and the digit lookup result.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int unsigned MaxBase   = 16;   // largest usable radix
  localparam int unsigned AlphaSize = 16;   // alphabet slots in the registers
  localparam int unsigned IdxW      = 4;    // digit index width

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned LenW      = 5;

  localparam logic [CfgIdxW-1:0] CFG_ALPHA_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_HIGH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BASE_LEN   = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [3:0] {
    PH_SPACE = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic            base_ok;  // alphabet and radix usable
    logic            hit;      // character found among the digits in use
    logic [IdxW-1:0] index;    // digit value of the character
  } digit_t;

  function automatic logic is_space(logic [7:0] c);
    return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
  endfunction

endpackage

### src/cbs_if.sv
// ----------------------------------------------------------------------------
// cbs_in_if / cbs_out_if: request channels of the string parser
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface cbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface cbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

### src/cbs_alphabet.sv
// ----------------------------------------------------------------------------
// cbs_alphabet: alphabet check and digit lookup
// Validates the configured alphabet and matches one character against it.
// ----------------------------------------------------------------------------
module cbs_alphabet import cbs_pkg::*; (
  input  logic [CfgDataW-1:0] alpha_low_i,
  input  logic [CfgDataW-1:0] alpha_high_i,
  input  logic [LenW-1:0]     base_len_i,
  input  logic [7:0]          character_i,
  output digit_t              digit_o
);

  logic [2*CfgDataW-1:0] alpha_all;
  logic [7:0]            alpha_ch [AlphaSize];
  logic [AlphaSize-1:0]  in_use;
  logic [AlphaSize-1:0]  bad_char;
  logic [AlphaSize-1:0]  dup;
  logic [AlphaSize-1:0]  match;
  logic                  len_ok;
  logic [IdxW-1:0]       index;

  assign alpha_all = {alpha_high_i, alpha_low_i};
  assign len_ok    = (base_len_i >= LenW'(2)) && (base_len_i <= LenW'(MaxBase));

  always_comb begin
    for (int i = 0; i < AlphaSize; i++) begin
      alpha_ch[i] = alpha_all[i*8 +: 8];
      in_use[i]   = LenW'(i) < base_len_i;
      bad_char[i] = in_use[i] && ((alpha_ch[i] == CHAR_NUL) || is_space(alpha_ch[i]) ||
                    (alpha_ch[i] == CHAR_PLUS) || (alpha_ch[i] == CHAR_MINUS));
      match[i]    = in_use[i] && (alpha_ch[i] == character_i);
    end
    // a later slot in use implies every earlier one is in use
    for (int i = 0; i < AlphaSize; i++) begin
      dup[i] = 1'b0;
      for (int j = i + 1; j < AlphaSize; j++) begin
        if (in_use[j] && (alpha_ch[i] == alpha_ch[j])) begin
          dup[i] = 1'b1;
        end
      end
    end
    // lowest matching slot wins
    index = '0;
    for (int i = AlphaSize - 1; i >= 0; i--) begin
      if (match[i]) begin
        index = IdxW'(i);
      end
    end
  end

  assign digit_o.base_ok = len_ok && (bad_char == '0) && (dup == '0);
  assign digit_o.hit     = match != '0;
  assign digit_o.index   = index;

endmodule

### src/custom_base_string_to_int_top.sv
// ----------------------------------------------------------------------------
// custom_base_string_to_int_top: string to integer parser, custom digit set
// Parses a character stream into a signed 32-bit value in a configured radix.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character per request, with last marking the end of a
//   string. out_ch carries one signed 32-bit value per string, issued for the
//   request marked last; other requests give no output.
//   The cfg port writes alphabet_low (index 0), alphabet_high (index 1) and
//   base_length (index 2); write only while no string is in flight.
//   A character is held in the input register; a last one moves its value
//   into the out_ch register when it advances. Throughput: one character
//   per cycle unless out_ch blocks a last one. The parse state (phase, sign,
//   accumulator) is updated by a single 32x5 multiply-add per character.
//   Reset clears the configuration to zero, the parse state to skipping
//   whitespace, and both channel registers to empty.
//   When out_ch stalls with a value pending, characters without last still
//   flow; a second last character waits in the input register, and in_ch
//   drops ready until the pending value is taken.
// ----------------------------------------------------------------------------
module custom_base_string_to_int_top import cbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  cbs_in_if.sink              in_ch,
  cbs_out_if.source           out_ch
);

  logic [CfgDataW-1:0] alpha_low_q, alpha_high_q;
  logic [LenW-1:0]     base_len_q;

  logic                in_valid_q;
  logic [7:0]          in_char_q;
  logic                in_last_q;

  phase_e              phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [31:0]         acc_q, acc_d;

  logic                out_valid_q;
  logic signed [31:0]  value_q;
  logic [31:0]         value_d;

  logic                adv;
  logic                take_in;
  digit_t              digit;
  logic [31:0]         prod;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_low_q  <= '0;
      alpha_high_q <= '0;
      base_len_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ALPHA_LOW) begin
        alpha_low_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_ALPHA_HIGH) begin
        alpha_high_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_BASE_LEN) begin
        base_len_q <= cfg_data_i[LenW-1:0];
      end
    end
  end

  // advance the input register unless it holds a last request blocked by the output
  assign adv         = in_valid_q && (!in_last_q || !out_valid_q || out_ch.ready);
  assign take_in     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_char_q <= in_ch.character;
      in_last_q <= in_ch.last;
    end
  end

  cbs_alphabet u_alphabet (
    .alpha_low_i  (alpha_low_q),
    .alpha_high_i (alpha_high_q),
    .base_len_i   (base_len_q),
    .character_i  (in_char_q),
    .digit_o      (digit)
  );

  // product wraps to 32 bits like the accumulator
  assign prod = acc_q * 32'(base_len_q);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if ((phase_d == PH_SPACE) && !is_space(in_char_q)) begin
      phase_d = PH_SIGN;
    end
    if (phase_d == PH_SIGN) begin
      if (in_char_q == CHAR_MINUS) begin
        neg_d = !neg_q;
      end else if (in_char_q != CHAR_PLUS) begin
        phase_d = PH_DIGIT;
      end
    end
    if (phase_d == PH_DIGIT) begin
      if (digit.base_ok && digit.hit) begin
        acc_d = prod + 32'(digit.index);
      end else begin
        phase_d = PH_STOP;
      end
    end
    value_d = '0;
    if (digit.base_ok) begin
      value_d = neg_d ? (32'd0 - acc_d) : acc_d;
    end
  end

  // parse state; drop back to the start after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else if (adv) begin
      if (in_last_q) begin
        phase_q <= PH_SPACE;
        neg_q   <= 1'b0;
        acc_q   <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      value_q <= value_d;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.value = value_q;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> (in_valid_q && in_last_q && out_valid_q && !out_ch.ready))
    else $error("input stalled without a blocked result");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && in_last_q))
    else $error("result appeared without a last character");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> (phase_q == PH_SPACE && !neg_q && acc_q == 32'd0))
    else $error("parse state not cleared after last character");

  a_stop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !in_last_q && phase_q == PH_STOP) |=> ($stable(acc_q) && phase_q == PH_STOP))
    else $error("stopped parse changed state");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the custom-base string to integer parser
// Drives strings one character per request with random gaps on both
// channels. A cycle-free model of the parser predicts one value per string.
// Each returned value is checked in order against that prediction, across
// many valid and broken alphabets.
// ----------------------------------------------------------------------------
module tb_top;
  import cbs_pkg::*;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cbs_in_if  in_ch ();
  cbs_out_if out_ch ();

  custom_base_string_to_int_top DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #6 clk_i = ~clk_i;

  // Parser model: configuration and per-string parse state
  logic [63:0]        alpha_lo;
  logic [63:0]        alpha_hi;
  logic [LenW-1:0]    radix;
  phase_e             parse_phase;
  logic               parse_neg;
  logic [31:0]        parse_acc;
  logic signed [31:0] expected_values[$];

  int fail_count;
  int items_sent;
  int rx_hold;
  bit tx_idle;
  bit rx_idle;

  function automatic logic [7:0] slot_byte(int k);
    return (k < 8) ? alpha_lo[k*8 +: 8] : alpha_hi[(k-8)*8 +: 8];
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
  endfunction

  function automatic bit digit_allowed(logic [7:0] c);
    return c != CHAR_NUL && !is_blank(c) && c != CHAR_PLUS && c != CHAR_MINUS;
  endfunction

  function automatic bit radix_usable();
    if (radix < 2 || radix > MaxBase) return 1'b0;
    for (int i = 0; i < radix; i++) begin
      if (!digit_allowed(slot_byte(i))) return 1'b0;
      for (int j = i + 1; j < radix; j++)
        if (slot_byte(j) == slot_byte(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the model by one character; queue a value on the last one.
  function automatic void parse_char(logic [7:0] c, logic lst);
    bit          usable;
    bit          hit;
    logic [3:0]  idx;
    logic [31:0] val;
    usable = radix_usable();
    hit    = 1'b0;
    idx    = '0;
    if (parse_phase == PH_SPACE && !is_blank(c)) parse_phase = PH_SIGN;
    if (parse_phase == PH_SIGN) begin
      if (c == CHAR_MINUS) parse_neg = ~parse_neg;
      else if (c != CHAR_PLUS) parse_phase = PH_DIGIT;
    end
    if (parse_phase == PH_DIGIT) begin
      if (usable)
        for (int k = 0; k < radix && k < 16; k++)
          if (!hit && slot_byte(k) == c) begin
            hit = 1'b1;
            idx = k[3:0];
          end
      if (!hit) parse_phase = PH_STOP;
      else parse_acc = parse_acc * 32'(radix) + 32'(idx);
    end
    if (lst) begin
      val = '0;
      if (usable) val = parse_neg ? (32'd0 - parse_acc) : parse_acc;
      expected_values.push_back(val);
      parse_phase = PH_SPACE;
      parse_neg   = 1'b0;
      parse_acc   = '0;
    end
  endfunction

  // Write all three registers back to back; call only while idle.
  task automatic write_config(logic [63:0] lo, logic [63:0] hi, logic [63:0] len_data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ALPHA_LOW;
    cfg_data_i <= lo;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_ALPHA_HIGH;
    cfg_data_i <= hi;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_BASE_LEN;
    cfg_data_i <= len_data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    alpha_lo = lo;
    alpha_hi = hi;
    radix    = len_data[LenW-1:0];
  endtask

  // Offer one character; returns at the falling edge after acceptance.
  task automatic send_char(logic [7:0] c, logic lst);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.character <= c;
    in_ch.last      <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    parse_char(c, lst);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold the input until every expected value is back, then let the pipe settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_values.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] bad_byte();
    case ($urandom_range(0, 3))
      0:       return CHAR_NUL;
      1:       return CHAR_PLUS;
      2:       return CHAR_MINUS;
      default: return ($urandom_range(0, 5) == 5) ? CHAR_SPACE : 8'(9 + $urandom_range(0, 4));
    endcase
  endfunction

  task automatic random_alphabet(output logic [63:0] lo, output logic [63:0] hi,
                                 output logic [63:0] len_data);
    logic [7:0] slots[16];
    bit         used[256];
    logic [7:0] b;
    int         n;
    int         j;
    int         k;
    used = '{default: 1'b0};
    case ($urandom_range(0, 5))
      0:       n = 2;
      1:       n = 16;
      default: n = $urandom_range(2, 16);
    endcase
    foreach (slots[i]) slots[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(1, 255)); while (!digit_allowed(b) || used[b]);
      used[b]  = 1'b1;
      slots[i] = b;
    end
    // Break roughly one alphabet in four
    case ($urandom_range(0, 15))
      0: n = $urandom_range(0, 1);
      1: n = $urandom_range(17, 31);
      2: begin
        j = $urandom_range(1, n - 1);
        k = $urandom_range(0, j - 1);
        slots[j] = slots[k];
      end
      3: begin
        k = $urandom_range(0, 1) ? n - 1 : $urandom_range(0, n - 1);
        slots[k] = bad_byte();
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = slots[i];
      hi[i*8 +: 8] = slots[i+8];
    end
    len_data = {$urandom, $urandom};
    len_data[LenW-1:0] = n[LenW-1:0];
  endtask

  function automatic logic [7:0] random_digit();
    int lim;
    lim = (radix >= 2 && radix <= 16) ? int'(radix) : 16;
    return slot_byte($urandom_range(0, lim - 1));
  endfunction

  task automatic send_string(bit well_formed);
    logic [7:0] s[$];
    int         n_dig;
    if (well_formed) begin
      repeat ($urandom_range(0, 3))
        s.push_back(($urandom_range(0, 5) == 5) ? CHAR_SPACE : 8'(9 + $urandom_range(0, 4)));
      repeat ($urandom_range(0, 3))
        s.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
      // Mostly short numbers, now and then long enough to wrap
      n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 34) : $urandom_range(0, 12);
      repeat (n_dig) s.push_back(random_digit());
      repeat ($urandom_range(0, 2)) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6))
        case ($urandom_range(0, 3))
          0:       s.push_back(bad_byte());
          1:       s.push_back(random_digit());
          default: s.push_back(8'($urandom_range(0, 255)));
        endcase
    end
    if (s.size() == 0) s.push_back(random_digit());
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic test_reset_state();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_char("1", 1'b1);
    wait_idle();
  endtask

  task automatic test_directed_strings();
    write_config("76543210", {48'd0, "98"}, 64'd10);
    send_char(CHAR_TAB, 1'b0);
    send_char(CHAR_CR, 1'b0);
    send_char(CHAR_SPACE, 1'b0);
    send_char(CHAR_MINUS, 1'b0);
    send_char(CHAR_PLUS, 1'b0);
    send_char("9", 1'b1);
    send_char(8'hFF, 1'b1);
    // Characters after the stop are ignored
    send_char("1", 1'b0);
    send_char("2", 1'b0);
    send_char("a", 1'b0);
    send_char("3", 1'b0);
    send_char("4", 1'b1);
    send_char(CHAR_NUL, 1'b0);
    send_char("5", 1'b1);
    wait_idle();
    // Plus sign in the last slot in use
    write_config("76543210", {48'd0, "+8"}, 64'd10);
    send_char("5", 1'b1);
    wait_idle();
    write_config({48'd0, "10"}, 64'd0, 64'd2);
    send_char("1", 1'b0);
    send_char("0", 1'b0);
    send_char("1", 1'b1);
    wait_idle();
    write_config("76543210", {8'hFF, "edcba98"}, 64'd16);
    send_char(8'hFF, 1'b0);
    send_char(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 150;
    repeat (60) send_char($urandom_range(0, 1) ? random_digit() : 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
    send_char(random_digit(), 1'b1);
    wait_idle();
  endtask

  task automatic test_random_strings();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_data;
    int          start;
    repeat (12) begin
      random_alphabet(lo, hi, len_data);
      write_config(lo, hi, len_data);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      start   = items_sent;
      while (items_sent - start < 100) send_string($urandom_range(0, 4) != 0);
      wait_idle();
    end
  endtask

  // Result side: random stalls, in-order check against the model
  initial begin
    int                 gap;
    logic signed [31:0] want;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = rx_idle ? $urandom_range(0, 12) : 0;
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (expected_values.size() == 0) begin
        $error("unexpected value %0d with no string pending", out_ch.value);
        fail_count++;
      end else begin
        want = expected_values.pop_front();
        if (out_ch.value !== want) begin
          $error("value mismatch: expected %0d, actual %0d", want, out_ch.value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.character = '0;
    in_ch.last      = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_ALPHA_LOW;
    cfg_data_i      = '0;
    fail_count      = 0;
    items_sent      = 0;
    rx_hold         = 0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    alpha_lo        = '0;
    alpha_hi        = '0;
    radix           = '0;
    parse_phase     = PH_SPACE;
    parse_neg       = 1'b0;
    parse_acc       = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_directed_strings();
    test_backpressure();
    test_random_strings();
    wait_idle();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #(12 * 300000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

### custom_base_string_to_int_top.f
src/cbs_pkg.sv
src/cbs_if.sv
src/cbs_alphabet.sv
src/custom_base_string_to_int_top.sv
tb/tb_top.sv
